// ----- src/passive_reply_address_parser_defines.svh -----
// Assertion macros shared by the parser RTL.
`ifndef PASSIVE_REPLY_ADDRESS_PARSER_DEFINES_SVH
`define PASSIVE_REPLY_ADDRESS_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PRA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pra_pkg.sv -----
package pra_pkg;

	// Fixed reply prefix
	localparam int PREFIX_LEN = 27;
	localparam int NUM_COUNT  = 6;

	localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{
		"2", "2", "7", " ", "E", "n", "t", "e", "r", "i", "n", "g", " ",
		"P", "a", "s", "s", "i", "v", "e", " ", "M", "o", "d", "e", " ", "("
	};

	localparam logic [7:0] CH_COMMA = ",";
	localparam logic [7:0] CH_CLOSE = ")";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";

	// Result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_PREFIX = 3'd1;
	localparam logic [2:0] ST_INVALID    = 3'd2;
	localparam logic [2:0] ST_TOO_MANY   = 3'd3;
	localparam logic [2:0] ST_TOO_LONG   = 3'd4;
	localparam logic [2:0] ST_TOO_FEW    = 3'd5;
	localparam logic [2:0] ST_OVER_255   = 3'd6;

	typedef enum logic [1:0] {
		PH_PREFIX = 2'd0,
		PH_BODY   = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
		logic       last;
	} char_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  host_byte_0;
		logic [7:0]  host_byte_1;
		logic [7:0]  host_byte_2;
		logic [7:0]  host_byte_3;
		logic [15:0] port;
	} res_beat_t;

endpackage

// ----- src/passive_reply_address_parser.sv -----
// Passive-mode reply parser: takes one character of a reply line per beat and, once the
// line is decided (closing paren, an error, or the end of the line), gives exactly one
// result beat with a status code, four host bytes and the port; host bytes and port read
// zero unless the status is ok. Characters after the decision give nothing until a beat
// with first set starts the next line. A character is taken each cycle char_stall is low:
// the line state is updated and the result register loaded in the cycle the character is
// accepted, so a result shows in the cycle after its deciding character. The single result
// register is the only thing that holds input back: char_stall is high only while a result
// waits and res_stall is high.
`include "passive_reply_address_parser_defines.svh"

module passive_reply_address_parser #(
	parameter int MAX_BODY_LEN = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  pra_pkg::char_beat_t   char_beat,
	output logic                  res_valid,
	input  logic                  res_stall,
	output pra_pkg::res_beat_t    res_beat
);
	import pra_pkg::*;

	localparam int BodyW  = $clog2(MAX_BODY_LEN + 1);
	localparam int PosW   = $clog2(PREFIX_LEN + 1);
	localparam int IdxW   = $clog2(NUM_COUNT);

	// Line state
	phase_t             phase_q;
	logic [PosW-1:0]    prefix_pos_q;
	logic [IdxW-1:0]    field_index_q;
	logic [BodyW-1:0]   body_count_q;
	logic [7:0]         nums_q [NUM_COUNT];
	logic               overflow_q;

	// Result register
	logic               res_valid_q;
	res_beat_t          res_q;

	// Next-state and decode signals
	phase_t             cur_phase, nxt_phase;
	logic [PosW-1:0]    cur_pos, nxt_pos;
	logic [IdxW-1:0]    cur_idx, nxt_idx;
	logic [BodyW-1:0]   cur_body, nxt_body, body_inc;
	logic [7:0]         cur_nums [NUM_COUNT];
	logic [7:0]         nxt_nums [NUM_COUNT];
	logic               cur_ovf, nxt_ovf;
	logic               emit;
	logic [2:0]         emit_status;
	logic [11:0]        acc;
	logic               is_digit;
	logic               prefix_hit;
	logic               char_acc;
	res_beat_t          result;

	assign char_acc   = char_valid && !char_stall;
	assign char_stall = res_valid_q && res_stall;
	assign res_valid  = res_valid_q;
	assign res_beat   = res_q;

	// Per-character decode: a first beat starts from a cleared line
	always_comb begin
		cur_phase = char_beat.first ? PH_PREFIX : phase_q;
		cur_pos   = char_beat.first ? '0 : prefix_pos_q;
		cur_idx   = char_beat.first ? '0 : field_index_q;
		cur_body  = char_beat.first ? '0 : body_count_q;
		cur_ovf   = char_beat.first ? 1'b0 : overflow_q;
		for (int i = 0; i < NUM_COUNT; i++) begin
			cur_nums[i] = char_beat.first ? 8'd0 : nums_q[i];
		end

		nxt_phase   = cur_phase;
		nxt_pos     = cur_pos;
		nxt_idx     = cur_idx;
		nxt_body    = cur_body;
		nxt_ovf     = cur_ovf;
		nxt_nums    = cur_nums;
		emit        = 1'b0;
		emit_status = ST_OK;

		prefix_hit = (cur_pos < PosW'(PREFIX_LEN)) &&
			(char_beat.ch == PREFIX_TEXT[cur_pos[$clog2(PREFIX_LEN)-1:0]]);
		is_digit   = (char_beat.ch >= CH_ZERO) && (char_beat.ch <= CH_NINE);
		acc        = 12'({cur_nums[cur_idx], 3'b000}) + 12'({cur_nums[cur_idx], 1'b0})
			+ 12'(char_beat.ch[3:0]);
		body_inc   = cur_body + BodyW'(1);

		unique case (cur_phase)
			PH_PREFIX: begin
				if (!prefix_hit) begin
					emit        = 1'b1;
					emit_status = ST_BAD_PREFIX;
				end else begin
					nxt_pos = cur_pos + PosW'(1);
					if (cur_pos == PosW'(PREFIX_LEN - 1)) begin
						nxt_phase = PH_BODY;
					end
					if (char_beat.last) begin
						emit        = 1'b1;
						emit_status = ST_BAD_PREFIX;
					end
				end
			end
			PH_BODY: begin
				if (char_beat.ch == CH_CLOSE) begin
					emit = 1'b1;
					if (cur_idx < IdxW'(NUM_COUNT - 1)) begin
						emit_status = ST_TOO_FEW;
					end else if (cur_ovf) begin
						emit_status = ST_OVER_255;
					end else begin
						emit_status = ST_OK;
					end
				end else if (cur_body >= BodyW'(MAX_BODY_LEN)) begin
					emit        = 1'b1;
					emit_status = ST_TOO_LONG;
				end else if (!is_digit && char_beat.ch != CH_COMMA) begin
					emit        = 1'b1;
					emit_status = ST_INVALID;
				end else if (!is_digit && cur_idx >= IdxW'(NUM_COUNT - 1)) begin
					emit        = 1'b1;
					emit_status = ST_TOO_MANY;
				end else begin
					if (is_digit) begin
						// accumulate, saturating at 255
						if (acc > 12'd255) begin
							nxt_nums[cur_idx] = 8'd255;
							nxt_ovf           = 1'b1;
						end else begin
							nxt_nums[cur_idx] = acc[7:0];
						end
					end else begin
						nxt_idx = cur_idx + IdxW'(1);
					end
					nxt_body = body_inc;
					if (char_beat.last) begin
						emit        = 1'b1;
						emit_status = (body_inc == BodyW'(MAX_BODY_LEN)) ?
							ST_TOO_LONG : ST_INVALID;
					end
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (emit) begin
			nxt_phase = PH_DONE;
		end

		// Result payload, zero unless ok
		result = '0;
		result.status = emit_status;
		if (emit_status == ST_OK) begin
			result.host_byte_0 = nxt_nums[0];
			result.host_byte_1 = nxt_nums[1];
			result.host_byte_2 = nxt_nums[2];
			result.host_byte_3 = nxt_nums[3];
			result.port        = {nxt_nums[4], nxt_nums[5]};
		end
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_PREFIX;
			prefix_pos_q  <= '0;
			field_index_q <= '0;
			body_count_q  <= '0;
			overflow_q    <= 1'b0;
			for (int i = 0; i < NUM_COUNT; i++) begin
				nums_q[i] <= 8'd0;
			end
		end else if (char_acc) begin
			phase_q       <= nxt_phase;
			prefix_pos_q  <= nxt_pos;
			field_index_q <= nxt_idx;
			body_count_q  <= nxt_body;
			overflow_q    <= nxt_ovf;
			nums_q        <= nxt_nums;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (char_acc && emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (char_acc && emit) begin
			res_q <= result;
		end
	end

	// Checks
	`PRA_ASSERT_NOW(a_err_zero, res_valid_q && res_q.status != ST_OK,
		res_q.host_byte_0 == 8'd0 && res_q.host_byte_1 == 8'd0 &&
		res_q.host_byte_2 == 8'd0 && res_q.host_byte_3 == 8'd0 && res_q.port == 16'd0,
		"error result carries nonzero address or port")
	`PRA_ASSERT_NEXT(a_done_quiet, char_acc && !char_beat.first && phase_q == PH_DONE,
		$stable(res_q) && !$rose(res_valid_q),
		"result produced after the line was decided")
	`PRA_ASSERT_NOW(a_body_state, phase_q == PH_BODY,
		prefix_pos_q == PosW'(PREFIX_LEN) && field_index_q <= IdxW'(NUM_COUNT - 1) &&
		body_count_q <= BodyW'(MAX_BODY_LEN),
		"body state out of range")

endmodule

// ----- verif/tb.sv -----
module tb;
	import pra_pkg::*;

	localparam int BODY_LIMIT  = 24;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam int ITEM_GOAL   = 1100;

	logic       clk;
	logic       arst_n;
	logic       char_valid;
	logic       char_stall;
	char_beat_t char_beat;
	logic       res_valid;
	logic       res_stall;
	res_beat_t  res_beat;

	// Line state of the parse model
	phase_t     line_phase;
	int         pfx_pos;
	int         field_idx;
	int         body_len;
	logic [7:0] nums [NUM_COUNT];
	bit         over_seen;

	res_beat_t    pending_results [$];
	byte unsigned line_buf [$];
	int           mismatches;
	int           chars_sent;
	int           cycle_cnt;
	bit           idle_en;
	int           hold_reqs;
	int           hold_served;
	int           hold_left;

	passive_reply_address_parser #(
		.MAX_BODY_LEN(BODY_LIMIT)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_beat (char_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic void clear_line();
		line_phase = PH_PREFIX;
		pfx_pos    = 0;
		field_idx  = 0;
		body_len   = 0;
		over_seen  = 1'b0;
		foreach (nums[i]) nums[i] = '0;
	endfunction

	// Advance the line state by one character; returns 1 when the line gets decided
	function automatic bit parse_char(input char_beat_t b, output res_beat_t r);
		int         v;
		int         idx;
		bit         decided;
		bit         took;
		logic [2:0] st;
		decided = 1'b0;
		took    = 1'b0;
		st      = ST_OK;
		r       = '0;
		if (b.first)
			clear_line();
		if (line_phase == PH_PREFIX) begin
			if (b.ch != PREFIX_TEXT[pfx_pos]) begin
				decided = 1'b1;
				st      = ST_BAD_PREFIX;
			end else begin
				pfx_pos++;
				if (pfx_pos == PREFIX_LEN)
					line_phase = PH_BODY;
				if (b.last) begin
					decided = 1'b1;
					st      = ST_BAD_PREFIX;
				end
			end
		end else if (line_phase == PH_BODY) begin
			idx = (field_idx < NUM_COUNT) ? field_idx : NUM_COUNT - 1;
			if (b.ch == CH_CLOSE) begin
				decided = 1'b1;
				st = (field_idx < NUM_COUNT - 1) ? ST_TOO_FEW :
					(over_seen ? ST_OVER_255 : ST_OK);
			end else if (body_len >= BODY_LIMIT) begin
				decided = 1'b1;
				st      = ST_TOO_LONG;
			end else if (b.ch >= CH_ZERO && b.ch <= CH_NINE) begin
				v = int'(nums[idx]) * 10 + int'(b.ch - CH_ZERO);
				if (v > 255) begin
					v         = 255;
					over_seen = 1'b1;
				end
				nums[idx] = v[7:0];
				took      = 1'b1;
			end else if (b.ch == CH_COMMA) begin
				if (field_idx >= NUM_COUNT - 1) begin
					decided = 1'b1;
					st      = ST_TOO_MANY;
				end else begin
					field_idx++;
					took = 1'b1;
				end
			end else begin
				decided = 1'b1;
				st      = ST_INVALID;
			end
			if (took) begin
				body_len++;
				if (b.last) begin
					decided = 1'b1;
					st      = (body_len >= BODY_LIMIT) ? ST_TOO_LONG : ST_INVALID;
				end
			end
		end
		if (decided) begin
			line_phase = PH_DONE;
			r.status   = st;
			if (st == ST_OK) begin
				r.host_byte_0 = nums[0];
				r.host_byte_1 = nums[1];
				r.host_byte_2 = nums[2];
				r.host_byte_3 = nums[3];
				r.port        = {nums[4], nums[5]};
			end
		end
		return decided;
	endfunction

	// Offer one character beat and record what it should produce once taken
	task automatic send_char(input char_beat_t b);
		res_beat_t r;
		if (idle_en && $urandom_range(99) < 11) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_beat  <= b;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		chars_sent++;
		if (parse_char(b, r))
			pending_results = {pending_results, r};
	endtask

	task automatic put_byte(input byte unsigned c);
		line_buf = {line_buf, c};
	endtask

	task automatic put_text(input string t);
		foreach (t[i]) put_byte(t[i]);
	endtask

	task automatic put_prefix(input int n);
		for (int i = 0; i < n; i++) put_byte(PREFIX_TEXT[i]);
	endtask

	task automatic send_line(input bit with_first, input bit with_last);
		char_beat_t b;
		foreach (line_buf[i]) begin
			b.ch    = line_buf[i];
			b.first = with_first && (i == 0);
			b.last  = with_last && (i == line_buf.size() - 1);
			send_char(b);
		end
		line_buf.delete();
	endtask

	// One random reply: mostly well-formed with random numbers, some broken, some noise
	task automatic rand_line();
		int kind;
		int nnum;
		int cut;
		kind = $urandom_range(99);
		if (kind < 70) begin
			put_prefix(PREFIX_LEN);
			nnum = ($urandom_range(99) < 75) ? NUM_COUNT : $urandom_range(1, 8);
			for (int k = 0; k < nnum; k++) begin
				if (k != 0)
					put_byte(CH_COMMA);
				case ($urandom_range(19))
					0: ;
					1: put_text($sformatf("%0d", $urandom_range(256, 9999)));
					2: put_text($sformatf("00%0d", $urandom_range(255)));
					default: put_text($sformatf("%0d", $urandom_range(255)));
				endcase
			end
			case ($urandom_range(9))
				0: put_byte(8'($urandom_range(255)));
				1: ;
				default: put_byte(CH_CLOSE);
			endcase
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)));
		end else if (kind < 85) begin
			cut = $urandom_range(1, PREFIX_LEN);
			put_prefix(cut);
			line_buf[$urandom_range(0, cut - 1)] = 8'($urandom_range(255));
			if ($urandom_range(1))
				put_byte(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(255)));
		end
		send_line($urandom_range(9) != 0, $urandom_range(1));
	endtask

	task automatic test_good_lines();
		put_prefix(PREFIX_LEN);
		put_text("192,168,1,10,4,21)");
		send_line(1'b1, 1'b1);
		put_prefix(PREFIX_LEN);
		put_text("0,0,0,0,0,0)");
		send_line(1'b1, 1'b0);
		put_prefix(PREFIX_LEN);
		put_text("255,255,255,255,255,255)");
		send_line(1'b1, 1'b1);
		// empty numbers read as zero
		put_prefix(PREFIX_LEN);
		put_text(",,,,,)");
		send_line(1'b1, 1'b1);
		// body exactly at its length limit, then the close
		put_prefix(PREFIX_LEN);
		put_text("00000000000001,2,3,4,5,6)");
		send_line(1'b1, 1'b1);
	endtask

	task automatic test_prefix_errors();
		put_text("228 Entering");
		send_line(1'b1, 1'b1);
		put_prefix(7);
		send_line(1'b1, 1'b1);
		put_text("2");
		send_line(1'b1, 1'b1);
		put_prefix(PREFIX_LEN - 1);
		put_text("[");
		send_line(1'b1, 1'b0);
		// line ends right on the open paren
		put_prefix(PREFIX_LEN);
		send_line(1'b1, 1'b1);
	endtask

	task automatic test_body_errors();
		put_prefix(PREFIX_LEN);
		put_text("1,2,a");
		send_line(1'b1, 1'b1);
		put_prefix(PREFIX_LEN);
		put_text("1,2");
		send_line(1'b1, 1'b1);
		put_prefix(PREFIX_LEN);
		put_text("1,2,3,4,5,6,");
		send_line(1'b1, 1'b0);
		put_prefix(PREFIX_LEN);
		put_text("0000000000000000000000000");
		send_line(1'b1, 1'b0);
		put_prefix(PREFIX_LEN);
		put_text("000000000000000000000000");
		send_line(1'b1, 1'b1);
		put_prefix(PREFIX_LEN);
		put_text("1,2,3)");
		send_line(1'b1, 1'b1);
		put_prefix(PREFIX_LEN);
		put_text("1,2,3,4,5,256)");
		send_line(1'b1, 1'b1);
		put_prefix(PREFIX_LEN);
		put_text("999,1,1,1,1,1)");
		send_line(1'b1, 1'b1);
		// overflow loses to too few numbers
		put_prefix(PREFIX_LEN);
		put_text("300,1)");
		send_line(1'b1, 1'b1);
	endtask

	task automatic test_line_restart();
		// unfinished line cut short by a new first beat
		put_prefix(PREFIX_LEN);
		put_text("10,20");
		send_line(1'b1, 1'b0);
		put_prefix(PREFIX_LEN);
		put_text("10,20,30,40,50,60)");
		send_line(1'b1, 1'b1);
		// characters after the decision are dropped
		put_prefix(PREFIX_LEN);
		put_text("1,2,3,4,5,6)junk");
		send_line(1'b1, 1'b1);
		put_text("7,8)");
		send_line(1'b0, 1'b1);
	endtask

	// Random lines until the overall beat count is reached
	task automatic test_random_lines();
		while (chars_sent < ITEM_GOAL)
			rand_line();
	endtask

	task automatic test_no_idle();
		idle_en = 1'b0;
		repeat (6) rand_line();
		idle_en = 1'b1;
	endtask

	task automatic test_backpressure();
		// nothing offered while waiting for the hold to start
		char_valid <= 1'b0;
		idle_en = 1'b0;
		hold_reqs++;
		while (hold_left == 0) @(posedge clk);
		repeat (20) begin
			put_text("X");
			send_line(1'b1, 1'b1);
		end
		idle_en = 1'b1;
	endtask

	// Receiver stall: long hold on request, random otherwise while idle_en is set
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else if (hold_served != hold_reqs) begin
			hold_served <= hold_reqs;
			hold_left   <= HOLD_CYCLES;
			res_stall   <= 1'b1;
		end else begin
			res_stall <= idle_en && ($urandom_range(99) < 11);
		end
	end

	// Result check against the oldest pending beat
	always @(posedge clk) begin
		res_beat_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: status %0d", res_beat.status);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (res_beat.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_beat.status);
					mismatches++;
				end
				if (res_beat.host_byte_0 !== want.host_byte_0) begin
					$error("host_byte_0: expected %0d, got %0d",
						want.host_byte_0, res_beat.host_byte_0);
					mismatches++;
				end
				if (res_beat.host_byte_1 !== want.host_byte_1) begin
					$error("host_byte_1: expected %0d, got %0d",
						want.host_byte_1, res_beat.host_byte_1);
					mismatches++;
				end
				if (res_beat.host_byte_2 !== want.host_byte_2) begin
					$error("host_byte_2: expected %0d, got %0d",
						want.host_byte_2, res_beat.host_byte_2);
					mismatches++;
				end
				if (res_beat.host_byte_3 !== want.host_byte_3) begin
					$error("host_byte_3: expected %0d, got %0d",
						want.host_byte_3, res_beat.host_byte_3);
					mismatches++;
				end
				if (res_beat.port !== want.port) begin
					$error("port: expected %0d, got %0d", want.port, res_beat.port);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("passive_reply_address_parser regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_beat  = '0;
		idle_en    = 1'b1;
		clear_line();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_good_lines();
		test_prefix_errors();
		test_body_errors();
		test_line_restart();
		test_backpressure();
		test_no_idle();
		test_random_lines();

		char_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("passive_reply_address_parser regression: pass");
		else
			$display("passive_reply_address_parser regression: fail");
		$finish;
	end

endmodule
